[design/rhc_pkg.sv]
// Shared types and constants for the IPv4 receive header checker.
package rhc_pkg;

    localparam int unsigned MIN_HEADER   = 20;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;
    localparam logic [15:0] FRAG_MASK    = 16'h3fff;
    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;
    localparam logic [15:0] SUM_GOOD     = 16'hffff;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LOCAL_ADDRESS     = 3'd0;
    localparam logic [2:0] CFG_SUBNET_BROADCAST  = 3'd1;
    localparam logic [2:0] CFG_BROADCAST_ENABLED = 3'd2;
    localparam logic [2:0] CFG_PROTOCOL_LIST     = 3'd3;
    localparam logic [2:0] CFG_PROTOCOL_COUNT    = 3'd4;

    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        ST_DELIVER      = 2'd0,
        ST_MALFORMED    = 2'd1,
        ST_NOT_HERE     = 2'd2,
        ST_UNREGISTERED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [2:0]  protocol_slot;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [5:0]  header_bytes;
        logic [15:0] datagram_length;
        logic [15:0] payload_length;
    } t_out_item;

    // Header fields captured for one packet at its last byte.
    typedef struct packed {
        logic [15:0] length;
        logic [7:0]  ver_ihl;
        logic [15:0] total;
        logic [15:0] frag;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
        logic [15:0] sum;
    } t_snap;

    typedef struct packed {
        logic [31:0] local_address;
        logic [31:0] subnet_broadcast;
        logic        broadcast_enabled;
        logic [3:0]  slot_count;
    } t_cfg;

endpackage

[design/rhc_parser.sv]
// Input register, header field capture and checksum accumulation per byte.
module rhc_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rhc_pkg::t_in_item i_in_item,
    output logic           o_snap_valid,
    output rhc_pkg::t_snap o_snap,
    input  logic           i_take
);
    import rhc_pkg::*;

    logic     r_in_valid;
    t_in_item r_in_item;

    logic [15:0] r_count,  n_count;
    logic [7:0]  r_vl,     n_vl;
    logic [15:0] r_total,  n_total;
    logic [15:0] r_frag,   n_frag;
    logic [7:0]  r_proto,  n_proto;
    logic [31:0] r_src,    n_src;
    logic [31:0] r_dst,    n_dst;
    logic [15:0] r_sum,    n_sum;
    logic [7:0]  r_hold,   n_hold;

    logic  r_snap_valid;
    t_snap r_snap;

    logic        snap_ready;
    logic        consume;
    logic [15:0] idx;
    logic [7:0]  b;
    logic [15:0] hdr;
    logic [16:0] sum_wide;

    assign snap_ready = !r_snap_valid || i_take;
    assign consume    = r_in_valid && (!r_in_item.last_byte || snap_ready);
    assign o_in_ready = !r_in_valid || consume;
    assign idx        = r_count;
    assign b          = r_in_item.data_byte;

    always_comb begin
        n_vl    = r_vl;
        n_total = r_total;
        n_frag  = r_frag;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sum   = r_sum;
        n_hold  = r_hold;
        sum_wide = {1'b0, r_sum} + {1'b0, r_hold, b};

        if (idx == 16'd0) begin
            n_vl = b;
        end else if (idx == 16'd2) begin
            n_total = {b, 8'h00};
        end else if (idx == 16'd3) begin
            n_total = {r_total[15:8], b};
        end else if (idx == 16'd6) begin
            n_frag = {b, 8'h00};
        end else if (idx == 16'd7) begin
            n_frag = {r_frag[15:8], b};
        end else if (idx == 16'd9) begin
            n_proto = b;
        end else if (idx >= 16'd12 && idx < 16'd16) begin
            n_src = {r_src[23:0], b};
        end else if (idx >= 16'd16 && idx < 16'd20) begin
            n_dst = {r_dst[23:0], b};
        end

        // The header length comes from the first byte, even while it is taken.
        hdr = {8'h00, 2'b00, n_vl[3:0], 2'b00};
        if (idx < hdr) begin
            if (!idx[0]) begin
                n_hold = b;
            end else if (sum_wide[16]) begin
                n_sum = sum_wide[15:0] + 16'd1;
            end else begin
                n_sum = sum_wide[15:0];
            end
        end

        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vl    <= '0;
            r_total <= '0;
            r_frag  <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sum   <= '0;
            r_hold  <= '0;
        end else if (consume) begin
            if (r_in_item.last_byte) begin
                r_count <= '0;
                r_vl    <= '0;
                r_total <= '0;
                r_frag  <= '0;
                r_proto <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_sum   <= '0;
                r_hold  <= '0;
            end else begin
                r_count <= n_count;
                r_vl    <= n_vl;
                r_total <= n_total;
                r_frag  <= n_frag;
                r_proto <= n_proto;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_sum   <= n_sum;
                r_hold  <= n_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_ready) begin
            r_snap_valid <= consume && r_in_item.last_byte;
        end
        if (consume && r_in_item.last_byte) begin
            r_snap.length      <= n_count;
            r_snap.ver_ihl     <= n_vl;
            r_snap.total       <= n_total;
            r_snap.frag        <= n_frag;
            r_snap.protocol    <= n_proto;
            r_snap.source      <= n_src;
            r_snap.destination <= n_dst;
            r_snap.sum         <= n_sum;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

[design/rhc_verdict.sv]
// Packet verdict, protocol table match and the result register.
module rhc_verdict #(
    parameter int PROTOCOL_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_snap_valid,
    input  rhc_pkg::t_snap              i_snap,
    output logic                        o_take,
    input  rhc_pkg::t_cfg               i_cfg,
    input  logic [PROTOCOL_SLOTS*8-1:0] i_protocol_list,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rhc_pkg::t_out_item          o_out_item
);
    import rhc_pkg::*;

    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic [5:0]  hdr;
    logic [15:0] hdr16;
    logic        bad;
    logic        addr_ok;
    logic        found;
    logic [2:0]  slot;

    assign o_take = i_snap_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        hdr   = {i_snap.ver_ihl[3:0], 2'b00};
        hdr16 = {10'd0, hdr};
        bad = (i_snap.length < 16'(MIN_HEADER))
            || (i_snap.ver_ihl[7:4] != IP_VERSION_4)
            || (hdr16 < 16'(MIN_HEADER))
            || (hdr16 > i_snap.length)
            || (i_snap.total < hdr16)
            || (i_snap.total > i_snap.length)
            || (i_snap.sum != SUM_GOOD)
            || ((i_snap.frag & FRAG_MASK) != 16'd0);

        // The all-ones destination is never compared with the configured addresses.
        if (i_snap.destination == ALL_ONES) begin
            addr_ok = i_cfg.broadcast_enabled;
        end else begin
            addr_ok = (i_snap.destination == i_cfg.local_address)
                   || (i_snap.destination == i_cfg.subnet_broadcast);
        end

        // Lowest matching slot below the configured count wins.
        found = 1'b0;
        slot  = 3'd0;
        for (int i = 0; i < PROTOCOL_SLOTS; i++) begin
            if (!found && (4'(i) < i_cfg.slot_count)
                    && (i_protocol_list[i*8 +: 8] == i_snap.protocol)) begin
                found = 1'b1;
                slot  = 3'(i);
            end
        end

        n_out_item.source_address      = i_snap.source;
        n_out_item.destination_address = i_snap.destination;
        n_out_item.header_bytes        = hdr;
        n_out_item.datagram_length     = i_snap.total;
        n_out_item.protocol_slot       = 3'd0;
        n_out_item.payload_length      = 16'd0;
        if (bad) begin
            n_out_item.status = ST_MALFORMED;
        end else begin
            n_out_item.payload_length = i_snap.total - hdr16;
            if (!addr_ok) begin
                n_out_item.status = ST_NOT_HERE;
            end else if (!found) begin
                n_out_item.status = ST_UNREGISTERED;
            end else begin
                n_out_item.status        = ST_DELIVER;
                n_out_item.protocol_slot = slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (o_take) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_malformed_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_MALFORMED)
            |-> (o_out_item.payload_length == 16'd0))
        else $error("malformed result carries a payload length");

    a_slot_only_on_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_DELIVER)
            |-> (o_out_item.protocol_slot == 3'd0))
        else $error("protocol slot set on a result that is not delivered");

    a_slot_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_DELIVER)
            |-> ({1'b0, o_out_item.protocol_slot} < 4'(PROTOCOL_SLOTS)
                 && {1'b0, o_out_item.protocol_slot} < i_cfg.slot_count))
        else $error("delivered slot lies outside the protocol table");

    a_lengths_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_MALFORMED)
            |-> (o_out_item.header_bytes >= 6'(MIN_HEADER)
                 && o_out_item.datagram_length >= {10'd0, o_out_item.header_bytes}))
        else $error("accepted packet has inconsistent header lengths");

endmodule

[design/ipv4_receive_header_checker.sv]
// Top level: configuration registers and the byte parser feeding the verdict stage.
// Takes one packet byte per cycle with no gaps between packets, unless a stalled output holds back a last byte.
// The result for a packet passes, after its last byte transfers, through the
// input register, the captured-header register, then the result register.
// Output stalls back-pressure the input only when a last byte cannot be captured.
// Reset clears the configuration registers, the partial header state and all valids.
module ipv4_receive_header_checker #(
    parameter int PROTOCOL_SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rhc_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rhc_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [rhc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rhc_pkg::*;

    t_cfg                        r_cfg;
    logic [PROTOCOL_SLOTS*8-1:0] r_protocol_list;

    logic  snap_valid;
    t_snap snap;
    logic  take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg           <= '0;
            r_protocol_list <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOCAL_ADDRESS:     r_cfg.local_address     <= i_cfg_data[31:0];
                CFG_SUBNET_BROADCAST:  r_cfg.subnet_broadcast  <= i_cfg_data[31:0];
                CFG_BROADCAST_ENABLED: r_cfg.broadcast_enabled <= i_cfg_data[0];
                CFG_PROTOCOL_LIST:     r_protocol_list <= i_cfg_data[PROTOCOL_SLOTS*8-1:0];
                CFG_PROTOCOL_COUNT:    r_cfg.slot_count        <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    rhc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_take       (take)
    );

    rhc_verdict #(
        .PROTOCOL_SLOTS (PROTOCOL_SLOTS)
    ) u_verdict (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap_valid    (snap_valid),
        .i_snap          (snap),
        .o_take          (take),
        .i_cfg           (r_cfg),
        .i_protocol_list (r_protocol_list),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_item      (o_out_item)
    );

endmodule
